>>> rtl/fpr_pkg.sv
// Frame pool replacement: shared types and default sizes.
// Used by fpr_cell and frame_pool_replacement_top; depends on nothing.

package fpr_pkg;

   // Default sizes handed to the top-level parameters
   localparam int POOL_FRAMES_DEF   = 16;
   localparam int MAX_PROCESSES_DEF = 8;
   localparam int PAGE_BITS_DEF     = 20;

   // Fixed port widths
   localparam int PID_W       = 4;
   localparam int PORT_PAGE_W = 20;
   localparam int PORT_IDX_W  = 4;

   // Width wide enough to compare a process number against MAX_PROCESSES
   localparam int PID_CMP_W   = 7;

   typedef enum logic {
      CMD_FAULT   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   // Control part of the token that walks down the cell row
   typedef struct packed {
      logic    active;    // token present in this stage
      cmd_type cmd;       // fault or release
      logic    pending;   // fault still looking for its frame
      logic    all_used;  // pool was full at launch: pick the round-robin victim
   } token_ctrl_type;

endpackage

>>> rtl/fpr_cell.sv
// One frame of the pool: used bit, owner and page, plus one token stage.
// Depends on fpr_pkg; instantiated in a row by frame_pool_replacement_top.

module fpr_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 4,
   parameter int PAGE_W     = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   // token from the previous cell
   input  fpr_pkg::token_ctrl_type tok_ctrl_i,
   input  logic [fpr_pkg::PID_W-1:0] tok_pid_i,
   input  logic [PAGE_W-1:0]      tok_page_i,
   input  logic [IDX_W-1:0]       tok_victim_i,
   input  logic [IDX_W-1:0]       tok_frame_i,
   input  logic                   tok_evicted_i,
   input  logic [fpr_pkg::PID_W-1:0] tok_ev_pid_i,
   input  logic [PAGE_W-1:0]      tok_ev_page_i,
   // token to the next cell
   output fpr_pkg::token_ctrl_type tok_ctrl_o,
   output logic [fpr_pkg::PID_W-1:0] tok_pid_o,
   output logic [PAGE_W-1:0]      tok_page_o,
   output logic [IDX_W-1:0]       tok_victim_o,
   output logic [IDX_W-1:0]       tok_frame_o,
   output logic                   tok_evicted_o,
   output logic [fpr_pkg::PID_W-1:0] tok_ev_pid_o,
   output logic [PAGE_W-1:0]      tok_ev_page_o,
   // occupancy of this frame
   output logic                   used_o
);

   localparam logic [IDX_W-1:0] MyIndex = IDX_W'(CELL_INDEX);

   logic                          used_ff, used_in;
   logic [fpr_pkg::PID_W-1:0]     owner_ff, owner_in;
   logic [PAGE_W-1:0]             page_ff, page_in;

   fpr_pkg::token_ctrl_type       ctrl_ff, ctrl_in;
   logic [fpr_pkg::PID_W-1:0]     pid_ff, pid_in;
   logic [PAGE_W-1:0]             tpage_ff, tpage_in;
   logic [IDX_W-1:0]              victim_ff, victim_in;
   logic [IDX_W-1:0]              frame_ff, frame_in;
   logic                          evicted_ff, evicted_in;
   logic [fpr_pkg::PID_W-1:0]     ev_pid_ff, ev_pid_in;
   logic [PAGE_W-1:0]             ev_page_ff, ev_page_in;

   logic take;
   logic free_it;

   // Claim this frame: first free one, or the victim when the pool is full
   assign take = tok_ctrl_i.active && (tok_ctrl_i.cmd == fpr_pkg::CMD_FAULT) &&
                 tok_ctrl_i.pending &&
                 (tok_ctrl_i.all_used ? (tok_victim_i == MyIndex) : !used_ff);

   // Drop the frame when its owner is released
   assign free_it = tok_ctrl_i.active && (tok_ctrl_i.cmd == fpr_pkg::CMD_RELEASE) &&
                    used_ff && (owner_ff == tok_pid_i);

   always_comb begin
      used_in    = used_ff;
      owner_in   = owner_ff;
      page_in    = page_ff;
      ctrl_in    = tok_ctrl_i;
      pid_in     = tok_pid_i;
      tpage_in   = tok_page_i;
      victim_in  = tok_victim_i;
      frame_in   = tok_frame_i;
      evicted_in = tok_evicted_i;
      ev_pid_in  = tok_ev_pid_i;
      ev_page_in = tok_ev_page_i;
      if (take) begin
         used_in         = 1'b1;
         owner_in        = tok_pid_i;
         page_in         = tok_page_i;
         ctrl_in.pending = 1'b0;
         frame_in        = MyIndex;
         evicted_in      = used_ff;
         ev_pid_in       = used_ff ? owner_ff : '0;
         ev_page_in      = used_ff ? page_ff : '0;
      end else if (free_it) begin
         used_in = 1'b0;
      end
   end

   // Frame contents; only the used bit needs clearing
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      owner_ff <= owner_in;
      page_ff  <= page_in;
   end

   // Token stage towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      pid_ff     <= pid_in;
      tpage_ff   <= tpage_in;
      victim_ff  <= victim_in;
      frame_ff   <= frame_in;
      evicted_ff <= evicted_in;
      ev_pid_ff  <= ev_pid_in;
      ev_page_ff <= ev_page_in;
   end

   assign tok_ctrl_o    = ctrl_ff;
   assign tok_pid_o     = pid_ff;
   assign tok_page_o    = tpage_ff;
   assign tok_victim_o  = victim_ff;
   assign tok_frame_o   = frame_ff;
   assign tok_evicted_o = evicted_ff;
   assign tok_ev_pid_o  = ev_pid_ff;
   assign tok_ev_page_o = ev_page_ff;
   assign used_o        = used_ff;

endmodule

>>> rtl/frame_pool_replacement_top.sv
// Frame pool replacement top level: request/response control and the row of frame cells.
// Depends on fpr_pkg and fpr_cell.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | command, process_id, virtual_page
//   rsp_    | out       | rsp_valid / rsp_ready | frame_index, evicted, evicted_process,
//           |           |                       | evicted_page, bad_process
//
// A fault or release walks a token down the row of POOL_FRAMES cells, one cell per
// cycle, and a good request is answered once the token has left the last cell.
// A bad process number is answered in the next cycle without touching the table.
// One transaction is in flight at a time; req_ready also waits for the response slot.
// Synchronous reset frees every frame and sets the round-robin pointer to the last frame.

module frame_pool_replacement_top #(
   parameter int POOL_FRAMES   = fpr_pkg::POOL_FRAMES_DEF,
   parameter int MAX_PROCESSES = fpr_pkg::MAX_PROCESSES_DEF,
   parameter int PAGE_BITS     = fpr_pkg::PAGE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [fpr_pkg::PID_W-1:0]        req_process_id,
   input  logic [fpr_pkg::PORT_PAGE_W-1:0]  req_virtual_page,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fpr_pkg::PORT_IDX_W-1:0]   rsp_frame_index,
   output logic                             rsp_evicted,
   output logic [fpr_pkg::PID_W-1:0]        rsp_evicted_process,
   output logic [fpr_pkg::PORT_PAGE_W-1:0]  rsp_evicted_page,
   output logic                             rsp_bad_process
);

   localparam int IdxW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
   localparam logic [IdxW-1:0] LastFrame = IdxW'(POOL_FRAMES - 1);
   localparam logic [fpr_pkg::PID_CMP_W-1:0] MaxPid = fpr_pkg::PID_CMP_W'(MAX_PROCESSES);

   // Token bus between cells: element i feeds cell i
   fpr_pkg::token_ctrl_type          t_ctrl    [POOL_FRAMES+1];
   logic [fpr_pkg::PID_W-1:0]        t_pid     [POOL_FRAMES+1];
   logic [PAGE_BITS-1:0]             t_page    [POOL_FRAMES+1];
   logic [IdxW-1:0]                  t_victim  [POOL_FRAMES+1];
   logic [IdxW-1:0]                  t_frame   [POOL_FRAMES+1];
   logic                             t_evicted [POOL_FRAMES+1];
   logic [fpr_pkg::PID_W-1:0]        t_ev_pid  [POOL_FRAMES+1];
   logic [PAGE_BITS-1:0]             t_ev_page [POOL_FRAMES+1];
   logic [POOL_FRAMES-1:0]           used_vec;

   logic                             busy_ff, busy_in;
   logic [IdxW-1:0]                  ptr_ff, ptr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [fpr_pkg::PORT_IDX_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic                             rsp_evicted_ff, rsp_evicted_in;
   logic [fpr_pkg::PID_W-1:0]        rsp_ev_pid_ff, rsp_ev_pid_in;
   logic [fpr_pkg::PORT_PAGE_W-1:0]  rsp_ev_page_ff, rsp_ev_page_in;
   logic                             rsp_bad_ff, rsp_bad_in;

   logic                             accept;
   logic                             bad_pid;
   logic                             launch;
   logic                             done;
   logic                             all_used;
   logic [IdxW-1:0]                  victim;

   // Take a transaction when out of reset, idle and the response slot is free or emptying
   assign req_ready = !reset && !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign bad_pid   = (req_process_id == '0) ||
                      (fpr_pkg::PID_CMP_W'(req_process_id) > MaxPid);
   assign launch    = accept && !bad_pid;
   assign all_used  = &used_vec;
   assign victim    = (ptr_ff == LastFrame) ? '0 : ptr_ff + 1'b1;
   assign done      = t_ctrl[POOL_FRAMES].active;

   // Inject the token into the first cell
   always_comb begin
      t_ctrl[0].active   = launch;
      t_ctrl[0].cmd      = fpr_pkg::cmd_type'(req_command);
      t_ctrl[0].pending  = 1'b1;
      t_ctrl[0].all_used = all_used;
   end
   assign t_pid[0]     = req_process_id;
   assign t_page[0]    = PAGE_BITS'(req_virtual_page);
   assign t_victim[0]  = victim;
   assign t_frame[0]   = '0;
   assign t_evicted[0] = 1'b0;
   assign t_ev_pid[0]  = '0;
   assign t_ev_page[0] = '0;

   // Row of frame cells
   for (genvar i = 0; i < POOL_FRAMES; i++) begin : g_cell
      fpr_cell #(
         .CELL_INDEX (i),
         .IDX_W      (IdxW),
         .PAGE_W     (PAGE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .tok_ctrl_i    (t_ctrl[i]),
         .tok_pid_i     (t_pid[i]),
         .tok_page_i    (t_page[i]),
         .tok_victim_i  (t_victim[i]),
         .tok_frame_i   (t_frame[i]),
         .tok_evicted_i (t_evicted[i]),
         .tok_ev_pid_i  (t_ev_pid[i]),
         .tok_ev_page_i (t_ev_page[i]),
         .tok_ctrl_o    (t_ctrl[i+1]),
         .tok_pid_o     (t_pid[i+1]),
         .tok_page_o    (t_page[i+1]),
         .tok_victim_o  (t_victim[i+1]),
         .tok_frame_o   (t_frame[i+1]),
         .tok_evicted_o (t_evicted[i+1]),
         .tok_ev_pid_o  (t_ev_pid[i+1]),
         .tok_ev_page_o (t_ev_page[i+1]),
         .used_o        (used_vec[i])
      );
   end

   // Control: busy flag, round-robin pointer and response slot
   always_comb begin
      busy_in        = busy_ff;
      ptr_in         = ptr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_ev_pid_in  = rsp_ev_pid_ff;
      rsp_ev_page_in = rsp_ev_page_ff;
      rsp_bad_in     = rsp_bad_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (launch) begin
         busy_in = 1'b1;
      end

      // Answer a bad process number at once
      if (accept && bad_pid) begin
         rsp_valid_in   = 1'b1;
         rsp_frame_in   = '0;
         rsp_evicted_in = 1'b0;
         rsp_ev_pid_in  = '0;
         rsp_ev_page_in = '0;
         rsp_bad_in     = 1'b1;
      end

      // Token has left the last cell: capture its result
      if (done) begin
         busy_in        = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_frame_in   = fpr_pkg::PORT_IDX_W'(t_frame[POOL_FRAMES]);
         rsp_evicted_in = t_evicted[POOL_FRAMES];
         rsp_ev_pid_in  = t_ev_pid[POOL_FRAMES];
         rsp_ev_page_in = fpr_pkg::PORT_PAGE_W'(t_ev_page[POOL_FRAMES]);
         rsp_bad_in     = 1'b0;
         // Advance the pointer only when a full pool forced a victim
         if ((t_ctrl[POOL_FRAMES].cmd == fpr_pkg::CMD_FAULT) &&
             t_ctrl[POOL_FRAMES].all_used) begin
            ptr_in = t_victim[POOL_FRAMES];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ptr_ff       <= LastFrame;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_frame_ff   <= rsp_frame_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_ev_pid_ff  <= rsp_ev_pid_in;
      rsp_ev_page_ff <= rsp_ev_page_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_index     = rsp_frame_ff;
   assign rsp_evicted         = rsp_evicted_ff;
   assign rsp_evicted_process = rsp_ev_pid_ff;
   assign rsp_evicted_page    = rsp_ev_page_ff;
   assign rsp_bad_process     = rsp_bad_ff;

endmodule
